### src/i2c_eeprom_master_core_assert.svh
// assertion macros for the two-wire memory master
`ifndef I2C_EEPROM_MASTER_CORE_ASSERT_SVH
`define I2C_EEPROM_MASTER_CORE_ASSERT_SVH
`ifndef SYNTH
`define IEM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define IEM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IEM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define IEM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/iem_pkg.sv
// shared types and constants for the two-wire memory master
package iem_pkg;
  localparam int PageDepthDefault = 8;
  localparam logic [6:0] DevAddrReset = 7'd87;
  localparam logic [7:0] PhaseReset = 8'd5;
  localparam logic [15:0] GapReset = 16'd1000;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_LOAD = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  localparam logic [1:0] REG_DEV = 2'd0;
  localparam logic [1:0] REG_PHASE = 2'd1;
  localparam logic [1:0] REG_GAP = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NACK_ADDR = 2'd1;
  localparam logic [1:0] ST_NACK_DATA = 2'd2;
  localparam logic [1:0] ST_BAD = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] word_address;
    logic [7:0] write_data;
    logic [7:0] byte_count;
    logic sda_in;
  } item_t;

  typedef struct packed {
    logic scl_level;
    logic sda_pull_low;
    logic busy_res;
    logic read_valid;
    logic [7:0] read_byte;
    logic read_last;
    logic done_res;
    logic [1:0] status;
  } result_t;
endpackage

### src/iem_queue.sv
// small first-in first-out queue of packed words
module iem_queue #(
  parameter int Width = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic [Width-1:0] din,
  output logic full,
  input  logic pop,
  output logic empty,
  output logic [Width-1:0] dout
);
  logic [Width-1:0] slot [2];
  logic wptr, rptr;
  logic [1:0] count;

  assign full = count == 2'd2;
  assign empty = count == 2'd0;
  assign dout = slot[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr <= ~wptr;
      end
      if (pop && !empty) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end
endmodule

### src/iem_seq.sv
// bit sequencer: one input item per tick, one result per tick
module iem_seq #(
  parameter int PageDepth = iem_pkg::PageDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  iem_pkg::item_t in_item,
  output logic in_ready,
  output logic out_valid,
  output iem_pkg::result_t out_res,
  input  logic out_ready,
  input  logic [6:0] device_address,
  input  logic [7:0] phase_ticks,
  input  logic [15:0] write_gap_ticks
);
  import iem_pkg::*;

  localparam int FillW = $clog2(PageDepth + 1);
  localparam int IdxW = (PageDepth > 1) ? $clog2(PageDepth) : 1;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001, S_START_A = 16'h0002, S_START_B = 16'h0004,
    S_TX_LOW = 16'h0008, S_TX_HIGH = 16'h0010, S_ACK_LOW = 16'h0020,
    S_ACK_HIGH = 16'h0040, S_GAP = 16'h0080, S_RX_LOW = 16'h0100,
    S_RX_HIGH = 16'h0200, S_MACK_LOW = 16'h0400, S_MACK_HIGH = 16'h0800,
    S_RS_LOW = 16'h1000, S_STOP_A = 16'h2000, S_STOP_B = 16'h4000,
    S_STOP_C = 16'h8000
  } state_t;

  typedef enum logic [3:0] {
    R_DEV_W = 4'b0001, R_WORD = 4'b0010, R_DATA = 4'b0100, R_DEV_R = 4'b1000
  } role_t;

  state_t state, state_next, st;
  role_t role, role_next;
  logic [15:0] phase_counter, phase_counter_next;
  logic [3:0] bit_counter, bit_counter_next;
  logic [7:0] shift_register, shift_register_next;
  logic [7:0] bytes_remaining, bytes_remaining_next;
  logic [FillW-1:0] buffer_fill, buffer_fill_next;
  logic [7:0] saved_word_address, saved_word_address_next;
  logic [8:0] send_index, send_index_next;
  logic op_read, op_read_next;
  logic [1:0] err_code, err_code_next;
  logic [7:0] page_buffer [PageDepth];
  logic [7:0] buf_rd;
  logic fire;
  logic [15:0] len;
  result_t res;
  logic [7:0] sh_rx;

  assign fire = in_valid && in_ready;
  assign out_valid = fire;
  assign out_res = res;
  assign in_ready = out_ready;
  assign buf_rd = (send_index < 9'(PageDepth)) ? page_buffer[send_index[IdxW-1:0]] : 8'd0;
  assign sh_rx = {shift_register[6:0], in_item.sda_in};

  always_ff @(posedge clk) begin
    if (fire && state == S_IDLE && in_item.cmd == CMD_LOAD
        && buffer_fill < FillW'(PageDepth)) begin
      page_buffer[buffer_fill[IdxW-1:0]] <= in_item.write_data;
    end
  end

  always_comb begin
    state_next = state;
    role_next = role;
    phase_counter_next = phase_counter;
    bit_counter_next = bit_counter;
    shift_register_next = shift_register;
    bytes_remaining_next = bytes_remaining;
    buffer_fill_next = buffer_fill;
    saved_word_address_next = saved_word_address;
    send_index_next = send_index;
    op_read_next = op_read;
    err_code_next = err_code;
    res = '0;
    res.scl_level = 1'b1;
    if (state == S_IDLE) begin
      if (in_item.cmd == CMD_LOAD) begin
        if (buffer_fill < FillW'(PageDepth)) begin
          buffer_fill_next = buffer_fill + 1'b1;
        end
      end else if (in_item.cmd == CMD_WRITE || in_item.cmd == CMD_READ) begin
        if ((in_item.cmd == CMD_READ && in_item.byte_count == 8'd0)
            || (in_item.cmd == CMD_WRITE
                && {1'b0, in_item.byte_count} > 9'(buffer_fill))) begin
          res.done_res = 1'b1;
          res.status = ST_BAD;
          if (in_item.cmd == CMD_WRITE) begin
            buffer_fill_next = '0;
          end
        end else begin
          op_read_next = in_item.cmd == CMD_READ;
          role_next = R_DEV_W;
          err_code_next = ST_OK;
          send_index_next = '0;
          saved_word_address_next = in_item.word_address;
          bytes_remaining_next = in_item.byte_count;
          state_next = S_START_A;
          phase_counter_next = '0;
        end
      end
    end
    st = state_next;
    res.busy_res = st != S_IDLE;
    case (st)
      S_START_B: res.sda_pull_low = 1'b1;
      S_TX_LOW: begin
        res.scl_level = 1'b0;
        res.sda_pull_low = !shift_register_next[7];
      end
      S_TX_HIGH: res.sda_pull_low = !shift_register_next[7];
      S_ACK_LOW, S_GAP, S_RX_LOW, S_RS_LOW: res.scl_level = 1'b0;
      S_MACK_LOW: begin
        res.scl_level = 1'b0;
        res.sda_pull_low = bytes_remaining_next != 8'd0;
      end
      S_MACK_HIGH: res.sda_pull_low = bytes_remaining_next != 8'd0;
      S_STOP_A: begin
        res.scl_level = 1'b0;
        res.sda_pull_low = 1'b1;
      end
      S_STOP_B: res.sda_pull_low = 1'b1;
      default: ;
    endcase
    len = (st == S_GAP) ? write_gap_ticks
        : ((phase_ticks != 8'd0) ? {8'd0, phase_ticks} : 16'd1);
    if (st != S_IDLE) begin
      if ({1'b0, phase_counter_next} + 17'd1 < {1'b0, len}) begin
        phase_counter_next = phase_counter_next + 16'd1;
      end else begin
        phase_counter_next = '0;
        case (st)
          S_START_A: state_next = S_START_B;
          S_START_B: begin
            state_next = S_TX_LOW;
            bit_counter_next = '0;
            shift_register_next = {device_address, role_next == R_DEV_R};
          end
          S_TX_LOW: state_next = S_TX_HIGH;
          S_TX_HIGH: begin
            bit_counter_next = bit_counter_next + 4'd1;
            shift_register_next = {shift_register_next[6:0], 1'b0};
            state_next = (bit_counter_next >= 4'd8) ? S_ACK_LOW : S_TX_LOW;
          end
          S_ACK_LOW: state_next = S_ACK_HIGH;
          S_ACK_HIGH: begin
            if (role_next == R_DATA) begin
              if (in_item.sda_in) begin
                err_code_next = ST_NACK_DATA;
              end
              if (bytes_remaining_next != 8'd0) begin
                bytes_remaining_next = bytes_remaining_next - 8'd1;
              end
              send_index_next = send_index_next + 9'd1;
              if (write_gap_ticks != 16'd0) begin
                state_next = S_GAP;
              end else if (err_code_next != ST_OK || bytes_remaining_next == 8'd0) begin
                state_next = S_STOP_A;
              end else begin
                role_next = R_DATA;
                state_next = S_TX_LOW;
                bit_counter_next = '0;
                shift_register_next = (send_index_next < 9'(PageDepth))
                    ? page_buffer[send_index_next[IdxW-1:0]] : 8'd0;
              end
            end else if (in_item.sda_in) begin
              err_code_next = ST_NACK_ADDR;
              state_next = S_STOP_A;
            end else if (role_next == R_DEV_W) begin
              role_next = R_WORD;
              state_next = S_TX_LOW;
              bit_counter_next = '0;
              shift_register_next = saved_word_address_next;
            end else if (role_next == R_WORD) begin
              if (op_read_next) begin
                state_next = S_RS_LOW;
              end else if (bytes_remaining_next == 8'd0) begin
                state_next = S_STOP_A;
              end else begin
                role_next = R_DATA;
                state_next = S_TX_LOW;
                bit_counter_next = '0;
                shift_register_next = buf_rd;
              end
            end else begin
              state_next = S_RX_LOW;
              bit_counter_next = '0;
              shift_register_next = '0;
            end
          end
          S_GAP: begin
            if (err_code_next != ST_OK || bytes_remaining_next == 8'd0) begin
              state_next = S_STOP_A;
            end else begin
              role_next = R_DATA;
              state_next = S_TX_LOW;
              bit_counter_next = '0;
              shift_register_next = buf_rd;
            end
          end
          S_RS_LOW: begin
            role_next = R_DEV_R;
            state_next = S_START_A;
          end
          S_RX_LOW: state_next = S_RX_HIGH;
          S_RX_HIGH: begin
            shift_register_next = sh_rx;
            bit_counter_next = bit_counter_next + 4'd1;
            if (bit_counter_next >= 4'd8) begin
              if (bytes_remaining_next != 8'd0) begin
                bytes_remaining_next = bytes_remaining_next - 8'd1;
              end
              res.read_valid = 1'b1;
              res.read_byte = sh_rx;
              res.read_last = bytes_remaining_next == 8'd0;
              state_next = S_MACK_LOW;
            end else begin
              state_next = S_RX_LOW;
            end
          end
          S_MACK_LOW: state_next = S_MACK_HIGH;
          S_MACK_HIGH: begin
            if (bytes_remaining_next != 8'd0) begin
              state_next = S_RX_LOW;
              bit_counter_next = '0;
              shift_register_next = '0;
            end else begin
              state_next = S_STOP_A;
            end
          end
          S_STOP_A: state_next = S_STOP_B;
          S_STOP_B: state_next = S_STOP_C;
          default: begin
            res.done_res = 1'b1;
            res.status = err_code_next;
            if (!op_read_next) begin
              buffer_fill_next = '0;
            end
            state_next = S_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      role <= R_DEV_W;
      phase_counter <= '0;
      bit_counter <= '0;
      shift_register <= '0;
      bytes_remaining <= '0;
      buffer_fill <= '0;
      saved_word_address <= '0;
      send_index <= '0;
      op_read <= 1'b0;
      err_code <= ST_OK;
    end else if (fire) begin
      state <= state_next;
      role <= role_next;
      phase_counter <= phase_counter_next;
      bit_counter <= bit_counter_next;
      shift_register <= shift_register_next;
      bytes_remaining <= bytes_remaining_next;
      buffer_fill <= buffer_fill_next;
      saved_word_address <= saved_word_address_next;
      send_index <= send_index_next;
      op_read <= op_read_next;
      err_code <= err_code_next;
    end
  end
endmodule

### src/i2c_eeprom_master_core.sv
// top level: input queue, bit sequencer and result queue
// path: each tick is registered in the input queue, its result in the result queue
// throughput: one tick per cycle; the sequencer takes a tick whenever the
// input queue holds one and the result queue has room
// reset: synchronous, clears the queues and the sequencer; registers return
// to address 87, 5 ticks per phase and a 1000 tick write gap
`include "i2c_eeprom_master_core_assert.svh"
module i2c_eeprom_master_core #(
  parameter int PageDepth = iem_pkg::PageDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [1:0] cmd,
  input  logic [7:0] word_address,
  input  logic [7:0] write_data,
  input  logic [7:0] byte_count,
  input  logic sda_in,
  output logic empty,
  input  logic pop,
  output logic scl_level,
  output logic sda_pull_low,
  output logic busy_res,
  output logic read_valid,
  output logic [7:0] read_byte,
  output logic read_last,
  output logic done_res,
  output logic [1:0] status,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import iem_pkg::*;

  logic [6:0] device_address;
  logic [7:0] phase_ticks;
  logic [15:0] write_gap_ticks;
  item_t in_word, q_item;
  result_t seq_res, out_word;
  logic q_empty, q_pop, rq_full, seq_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DevAddrReset;
      phase_ticks <= PhaseReset;
      write_gap_ticks <= GapReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEV: device_address <= cfg_data[6:0];
        REG_PHASE: phase_ticks <= cfg_data[7:0];
        REG_GAP: write_gap_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_word = '{cmd: cmd, word_address: word_address, write_data: write_data,
                     byte_count: byte_count, sda_in: sda_in};

  iem_queue #(.Width($bits(item_t))) u_in_q (
    .clk(clk), .rst(rst), .push(push), .din(in_word), .full(full),
    .pop(q_pop), .empty(q_empty), .dout(q_item)
  );

  iem_seq #(.PageDepth(PageDepth)) u_seq (
    .clk(clk), .rst(rst), .in_valid(!q_empty), .in_item(q_item), .in_ready(q_pop),
    .out_valid(seq_valid), .out_res(seq_res), .out_ready(!rq_full),
    .device_address(device_address), .phase_ticks(phase_ticks),
    .write_gap_ticks(write_gap_ticks)
  );

  iem_queue #(.Width($bits(result_t))) u_out_q (
    .clk(clk), .rst(rst), .push(seq_valid), .din(seq_res), .full(rq_full),
    .pop(pop), .empty(empty), .dout(out_word)
  );

  assign scl_level = out_word.scl_level;
  assign sda_pull_low = out_word.sda_pull_low;
  assign busy_res = out_word.busy_res;
  assign read_valid = out_word.read_valid;
  assign read_byte = out_word.read_byte;
  assign read_last = out_word.read_last;
  assign done_res = out_word.done_res;
  assign status = out_word.status;

  `IEM_ASSERT_IMPL(a_seq_space, clk, rst, seq_valid, !rq_full)
  `IEM_ASSERT_IMPL(a_done_busy, clk, rst, !empty && done_res && status != ST_BAD, busy_res)
  `IEM_ASSERT_IMPL(a_rd_high, clk, rst, !empty && read_valid, scl_level)
  `IEM_ASSERT_NEXT(a_status_q, clk, rst, !empty && !done_res, 1'b1)
endmodule

### tb/tb.sv
// self-checking testbench for the two-wire memory master: directed table and bus cases, then random bursts
module tb;
  import iem_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [4:0] {
    SQ_IDLE, SQ_START_A, SQ_START_B, SQ_TX_LOW, SQ_TX_HIGH, SQ_ACK_LOW, SQ_ACK_HIGH,
    SQ_GAP, SQ_RX_LOW, SQ_RX_HIGH, SQ_MACK_LOW, SQ_MACK_HIGH, SQ_RS_LOW,
    SQ_STOP_A, SQ_STOP_B, SQ_STOP_C
  } seq_e;
  typedef enum logic [1:0] {RL_DEV_W, RL_WORD, RL_DATA, RL_DEV_R} role_e;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } row_t;

  localparam int Depth = PageDepthDefault;
  localparam int TargetItems = 1150;
  localparam int CycleLimit = 3000000;

  logic clk, rst, push, full, empty, pop, cfg_we;
  logic [1:0] cmd, cfg_index;
  logic [7:0] word_address, write_data, byte_count;
  logic sda_in;
  logic [15:0] cfg_data;
  result_t got;

  i2c_eeprom_master_core DUT (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .cmd(cmd), .word_address(word_address), .write_data(write_data),
    .byte_count(byte_count), .sda_in(sda_in),
    .empty(empty), .pop(pop),
    .scl_level(got.scl_level), .sda_pull_low(got.sda_pull_low), .busy_res(got.busy_res),
    .read_valid(got.read_valid), .read_byte(got.read_byte), .read_last(got.read_last),
    .done_res(got.done_res), .status(got.status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // bus master shadow state
  logic [6:0]  m_dev;
  logic [7:0]  m_phase;
  logic [15:0] m_gap;
  seq_e        m_seq;
  int unsigned m_pc, m_sidx;
  logic [3:0]  m_bits, m_fill;
  logic [7:0]  m_shift, m_left, m_waddr;
  logic [7:0]  m_page [Depth];
  logic        m_read;
  role_e       m_role;
  logic [1:0]  m_err;

  result_t pending_ticks[$];
  int errors = 0;
  int sent = 0;
  bit calm = 0;
  bit nack_all = 0;
  longint cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void begin_byte(logic [7:0] b);
    m_seq = SQ_TX_LOW;
    m_bits = 0;
    m_shift = b;
  endfunction

  function automatic void data_or_stop();
    if (m_err != ST_OK || m_left == 0) m_seq = SQ_STOP_A;
    else begin
      m_role = RL_DATA;
      begin_byte(m_sidx < Depth ? m_page[m_sidx] : 8'h00);
    end
  endfunction

  function automatic result_t master_tick(item_t it);
    result_t r;
    seq_e st;
    int unsigned len;
    logic rd;
    r = '0;
    r.scl_level = 1;
    if (m_seq == SQ_IDLE) begin
      if (it.cmd == CMD_LOAD) begin
        if (m_fill < Depth) begin
          m_page[m_fill] = it.write_data;
          m_fill++;
        end
      end else if (it.cmd == CMD_WRITE || it.cmd == CMD_READ) begin
        rd = (it.cmd == CMD_READ);
        if ((rd && it.byte_count == 0) || (!rd && it.byte_count > m_fill)) begin
          r.done_res = 1;
          r.status = ST_BAD;
          if (!rd) m_fill = 0;
        end else begin
          m_read = rd;
          m_role = RL_DEV_W;
          m_err = ST_OK;
          m_sidx = 0;
          m_waddr = it.word_address;
          m_left = it.byte_count;
          m_seq = SQ_START_A;
          m_pc = 0;
        end
      end
    end
    st = m_seq;
    r.busy_res = (st != SQ_IDLE);
    case (st)
      SQ_START_B: r.sda_pull_low = 1;
      SQ_TX_LOW: begin
        r.scl_level = 0;
        r.sda_pull_low = !m_shift[7];
      end
      SQ_TX_HIGH: r.sda_pull_low = !m_shift[7];
      SQ_ACK_LOW, SQ_GAP, SQ_RX_LOW, SQ_RS_LOW: r.scl_level = 0;
      SQ_MACK_LOW: begin
        r.scl_level = 0;
        r.sda_pull_low = (m_left != 0);
      end
      SQ_MACK_HIGH: r.sda_pull_low = (m_left != 0);
      SQ_STOP_A: begin
        r.scl_level = 0;
        r.sda_pull_low = 1;
      end
      SQ_STOP_B: r.sda_pull_low = 1;
      default: ;
    endcase
    if (st != SQ_IDLE) begin
      len = (st == SQ_GAP) ? m_gap : (m_phase != 0 ? m_phase : 1);
      if (m_pc + 1 < len) m_pc++;
      else begin
        m_pc = 0;
        case (st)
          SQ_START_A: m_seq = SQ_START_B;
          SQ_START_B: begin_byte({m_dev, m_role == RL_DEV_R});
          SQ_TX_LOW: m_seq = SQ_TX_HIGH;
          SQ_TX_HIGH: begin
            m_bits++;
            m_shift = m_shift << 1;
            m_seq = (m_bits >= 8) ? SQ_ACK_LOW : SQ_TX_LOW;
          end
          SQ_ACK_LOW: m_seq = SQ_ACK_HIGH;
          SQ_ACK_HIGH: begin
            if (m_role == RL_DATA) begin
              if (it.sda_in) m_err = ST_NACK_DATA;
              if (m_left != 0) m_left--;
              m_sidx++;
              if (m_gap != 0) m_seq = SQ_GAP;
              else data_or_stop();
            end else if (it.sda_in) begin
              m_err = ST_NACK_ADDR;
              m_seq = SQ_STOP_A;
            end else if (m_role == RL_DEV_W) begin
              m_role = RL_WORD;
              begin_byte(m_waddr);
            end else if (m_role == RL_WORD) begin
              if (m_read) m_seq = SQ_RS_LOW;
              else data_or_stop();
            end else begin
              m_seq = SQ_RX_LOW;
              m_bits = 0;
              m_shift = 0;
            end
          end
          SQ_GAP: data_or_stop();
          SQ_RS_LOW: begin
            m_role = RL_DEV_R;
            m_seq = SQ_START_A;
          end
          SQ_RX_LOW: m_seq = SQ_RX_HIGH;
          SQ_RX_HIGH: begin
            m_shift = {m_shift[6:0], it.sda_in};
            m_bits++;
            if (m_bits >= 8) begin
              if (m_left != 0) m_left--;
              r.read_valid = 1;
              r.read_byte = m_shift;
              r.read_last = (m_left == 0);
              m_seq = SQ_MACK_LOW;
            end else m_seq = SQ_RX_LOW;
          end
          SQ_MACK_LOW: m_seq = SQ_MACK_HIGH;
          SQ_MACK_HIGH: begin
            if (m_left != 0) begin
              m_seq = SQ_RX_LOW;
              m_bits = 0;
              m_shift = 0;
            end else m_seq = SQ_STOP_A;
          end
          SQ_STOP_A: m_seq = SQ_STOP_B;
          SQ_STOP_B: m_seq = SQ_STOP_C;
          default: begin
            r.done_res = 1;
            r.status = m_err;
            if (!m_read) m_fill = 0;
            m_seq = SQ_IDLE;
          end
        endcase
      end
    end
    return r;
  endfunction

  function automatic bit hold_off();
    return !calm && $urandom_range(0, 99) < 8;
  endfunction

  // one transfer on the input side; expectation from the shadow master or typed in
  task automatic send(item_t it, bit typed = 0, result_t res = '0);
    result_t p;
    while (hold_off()) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    {cmd, word_address, write_data, byte_count, sda_in} <= it;
    forever begin
      @(negedge clk);
      if (!full) break;
      @(posedge clk);
    end
    @(posedge clk);
    p = master_tick(it);
    pending_ticks.push_back(typed ? res : p);
    sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    push <= 0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_DEV: m_dev = val[6:0];
      REG_PHASE: m_phase = val[7:0];
      default: m_gap = val;
    endcase
  endtask

  task automatic set_bus(logic [6:0] d, logic [7:0] ph, logic [15:0] g);
    write_reg(REG_DEV, {9'd0, d});
    write_reg(REG_PHASE, {8'd0, ph});
    write_reg(REG_GAP, g);
  endtask

  // ticks until the burst ends; acks mostly low unless nack_all is set, data bits random, stray commands ignored
  task automatic run_burst();
    item_t it;
    while (m_seq != SQ_IDLE) begin
      it.cmd = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(0, 3)) : CMD_TICK;
      it.word_address = 8'($urandom);
      it.write_data = 8'($urandom);
      it.byte_count = 8'($urandom);
      if (m_seq == SQ_ACK_HIGH) it.sda_in = nack_all ? 1'b1 : ($urandom_range(0, 19) == 0);
      else it.sda_in = 1'($urandom);
      send(it);
    end
  endtask

  function automatic item_t mk(logic [1:0] c, logic [7:0] a, logic [7:0] d, logic [7:0] n);
    return '{cmd: c, word_address: a, write_data: d, byte_count: n, sda_in: 1'b0};
  endfunction

  task automatic start_op(logic [1:0] c, logic [7:0] n);
    send(mk(c, 8'($urandom), 8'($urandom), n));
    run_burst();
  endtask

  always @(posedge clk) pop <= !hold_off();

  always @(negedge clk) begin
    if (pop && !empty && !rst) begin
      if (pending_ticks.size() == 0) begin
        $display("%0t unexpected result %p", $time, got);
        errors++;
      end else begin
        if (got !== pending_ticks[0]) begin
          $display("%0t expected %p actual %p", $time, pending_ticks[0], got);
          errors++;
        end
        void'(pending_ticks.pop_front());
      end
    end
  end

  row_t rows[$];
  result_t idle_res, bad_res;
  int k, n;

  initial begin
    rst = 1;
    push = 0;
    pop = 0;
    cfg_we = 0;
    cfg_index = REG_DEV;
    cfg_data = 0;
    {cmd, word_address, write_data, byte_count, sda_in} = '0;
    m_dev = DevAddrReset;
    m_phase = PhaseReset;
    m_gap = GapReset;
    m_seq = SQ_IDLE;
    m_pc = 0;
    m_sidx = 0;
    m_bits = 0;
    m_fill = 0;
    m_shift = 0;
    m_left = 0;
    m_waddr = 0;
    m_read = 0;
    m_role = RL_DEV_W;
    m_err = ST_OK;
    foreach (m_page[i]) m_page[i] = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    idle_res = '0;
    idle_res.scl_level = 1;
    bad_res = idle_res;
    bad_res.done_res = 1;
    bad_res.status = ST_BAD;
    rows.push_back('{mk(CMD_TICK, 8'h00, 8'h00, 8'h00), 1, idle_res});
    rows.push_back('{mk(CMD_READ, 8'hFF, 8'hFF, 8'h00), 1, bad_res});
    rows.push_back('{mk(CMD_WRITE, 8'h00, 8'h00, 8'h01), 1, bad_res});
    rows.push_back('{mk(CMD_LOAD, 8'h00, 8'h00, 8'hFF), 1, idle_res});
    rows.push_back('{mk(CMD_LOAD, 8'hFF, 8'hFF, 8'h00), 1, idle_res});
    rows.push_back('{mk(CMD_LOAD, 8'h00, 8'hA5, 8'h00), 1, idle_res});
    rows.push_back('{mk(CMD_LOAD, 8'h00, 8'h5A, 8'h00), 1, idle_res});
    rows.push_back('{mk(CMD_LOAD, 8'h00, 8'h01, 8'h00), 1, idle_res});
    rows.push_back('{mk(CMD_LOAD, 8'h00, 8'h80, 8'h00), 1, idle_res});
    rows.push_back('{mk(CMD_LOAD, 8'h00, 8'h7F, 8'h00), 1, idle_res});
    rows.push_back('{mk(CMD_LOAD, 8'h00, 8'hFE, 8'h00), 1, idle_res});
    rows.push_back('{mk(CMD_LOAD, 8'h00, 8'h33, 8'h00), 1, idle_res});
    rows.push_back('{mk(CMD_WRITE, 8'h00, 8'h00, 8'h09), 1, bad_res});
    rows.push_back('{mk(CMD_WRITE, 8'hFF, 8'h00, 8'h00), 0, idle_res});
    foreach (rows[i]) begin
      rows[i].it.sda_in = i[0];
      send(rows[i].it, rows[i].typed, rows[i].res);
      run_burst();
    end

    // fastest bus, no gap, full page write and a short read, then a nacked read and write
    set_bus(7'd0, 8'd1, 16'd0);
    for (k = 0; k < Depth; k++) send(mk(CMD_LOAD, 8'h00, 8'($urandom), 8'h00));
    send(mk(CMD_WRITE, 8'h3C, 8'h00, 8'(Depth)));
    run_burst();
    start_op(CMD_READ, 8'd3);
    nack_all = 1;
    start_op(CMD_READ, 8'd2);
    send(mk(CMD_LOAD, 8'h00, 8'h11, 8'h00));
    start_op(CMD_WRITE, 8'd1);
    nack_all = 0;
    // zero phase counts as one, then a top address with a short gap
    set_bus(7'd127, 8'd0, 16'd1);
    start_op(CMD_READ, 8'd1);
    set_bus(7'd127, 8'd1, 16'd2);
    send(mk(CMD_LOAD, 8'h00, 8'h96, 8'h00));
    start_op(CMD_WRITE, 8'd1);
    set_bus(7'($urandom), 8'd1, 16'd2);
    start_op(CMD_READ, 8'd4);

    while (sent < TargetItems) begin
      calm = (sent > 850 && sent < 1000);
      if ($urandom_range(0, 5) == 0)
        set_bus(7'($urandom), 8'($urandom_range(0, 3)), 16'($urandom_range(0, 4)));
      case ($urandom_range(0, 9))
        0: begin
          n = $urandom_range(1, 6);
          repeat (n) send(mk(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(0, 2))));
          run_burst();
        end
        1, 2, 3, 4: begin
          n = $urandom_range(0, 10);
          repeat (n) send(mk(CMD_LOAD, 8'($urandom), 8'($urandom), 8'($urandom)));
          k = ($urandom_range(0, 7) == 0) ? m_fill + 1 : $urandom_range(0, m_fill);
          nack_all = ($urandom_range(0, 11) == 0);
          start_op(CMD_WRITE, 8'(k));
        end
        default: begin
          nack_all = ($urandom_range(0, 11) == 0);
          start_op(CMD_READ, 8'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4)));
        end
      endcase
      nack_all = 0;
    end
    calm = 0;

    push <= 0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

### sim.f
+incdir+src
src/iem_pkg.sv
src/iem_queue.sv
src/iem_seq.sv
src/i2c_eeprom_master_core.sv
tb/tb.sv
